[sv/gtt_pkg.sv]
// ----------------------------------------------------------------------------
// gtt_pkg
// Shared types, constants and character-class functions of the grammar text
// tokenizer.
// ----------------------------------------------------------------------------
package gtt_pkg;

   localparam int POSITION_BITS = 16;
   localparam int LINE_BITS     = 16;
   localparam int LENGTH_BITS   = 8;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_OR     = 8'h7C;  // |
   localparam logic [7:0] CHAR_STAR   = 8'h2A;  // *
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;  // +
   localparam logic [7:0] CHAR_QMARK  = 8'h3F;  // ?
   localparam logic [7:0] CHAR_LPAREN = 8'h28;  // (
   localparam logic [7:0] CHAR_RPAREN = 8'h29;  // )
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;  // ;
   localparam logic [7:0] CHAR_HASH   = 8'h23;  // #
   localparam logic [7:0] CHAR_COLON  = 8'h3A;  // :
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;  // _
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   typedef enum logic [3:0] {
      KIND_OR          = 4'd0,
      KIND_STAR        = 4'd1,
      KIND_PLUS        = 4'd2,
      KIND_QMARK       = 4'd3,
      KIND_LPAREN      = 4'd4,
      KIND_RPAREN      = 4'd5,
      KIND_SEMICOLON   = 4'd6,
      KIND_RULENAME    = 4'd7,
      KIND_TERMINAL    = 4'd8,
      KIND_NONTERMINAL = 4'd9,
      KIND_END         = 4'd10
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    line_number;
      logic [15:0]    start_offset;
      logic [7:0]     token_length;
      logic           last_result;
   } rsp_type;

   // One step yields zero, one or two descriptors, first in slot a.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot_a;
      rsp_type    slot_b;
   } rsp_pair_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_lower(c) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDER) || (c == CHAR_COLON);
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CHAR_OR) || (c == CHAR_STAR) || (c == CHAR_PLUS) ||
             (c == CHAR_QMARK) || (c == CHAR_LPAREN) || (c == CHAR_RPAREN) ||
             (c == CHAR_SEMI);
   endfunction

   function automatic token_kind_type operator_kind(input logic [7:0] c);
      token_kind_type k;
      case (c)
         CHAR_OR:     k = KIND_OR;
         CHAR_STAR:   k = KIND_STAR;
         CHAR_PLUS:   k = KIND_PLUS;
         CHAR_QMARK:  k = KIND_QMARK;
         CHAR_LPAREN: k = KIND_LPAREN;
         CHAR_RPAREN: k = KIND_RPAREN;
         default:     k = KIND_SEMICOLON;
      endcase
      return k;
   endfunction

endpackage

[sv/gtt_lexer.sv]
// ----------------------------------------------------------------------------
// gtt_lexer
// Scan state and per-byte step: classify, extend or flush the pending lexeme.
// ----------------------------------------------------------------------------
module gtt_lexer
   import gtt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   text_byte,
   input  logic         end_of_text,
   output rsp_pair_type results
);

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_WORD    = 2'd1,
      MODE_OTHER   = 2'd2,
      MODE_COMMENT = 2'd3
   } mode_type;

   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

   mode_type                 mode_ff, mode_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] pstart_ff, pstart_in;
   logic [LENGTH_BITS-1:0]   plen_ff, plen_in;
   logic                     lower_ff, lower_in;
   logic                     colon_ff, colon_in;

   always_comb begin
      logic                     eot;
      logic                     pending;
      logic                     flush;
      logic                     emit_b;
      rsp_type                  flush_rsp;
      rsp_type                  b_rsp;
      logic [LENGTH_BITS-1:0]   flen;
      logic [LINE_BITS-1:0]     line_inc;
      logic [POSITION_BITS-1:0] pos_inc;

      eot      = end_of_text || (text_byte == CHAR_NUL);
      pending  = (mode_ff == MODE_WORD) || (mode_ff == MODE_OTHER);
      line_inc = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
      pos_inc  = pos_ff + 1'b1;

      // Descriptor of the pending lexeme, in case it is flushed.
      flen = plen_ff;
      if (mode_ff == MODE_WORD && colon_ff) begin
         flush_rsp.kind = KIND_RULENAME;
         if (plen_ff != LEN_MAX && plen_ff != '0) begin
            flen = plen_ff - 1'b1;
         end
      end else begin
         flush_rsp.kind = lower_ff ? KIND_NONTERMINAL : KIND_TERMINAL;
      end
      flush_rsp.line_number  = 16'(line_ff);
      flush_rsp.start_offset = 16'(pstart_ff);
      flush_rsp.token_length = 8'(flen);
      flush_rsp.last_result  = 1'b0;

      b_rsp.kind         = KIND_END;
      b_rsp.line_number  = 16'(line_ff);
      b_rsp.start_offset = 16'(pos_ff);
      b_rsp.token_length = '0;
      b_rsp.last_result  = 1'b1;

      mode_in   = mode_ff;
      line_in   = line_ff;
      pos_in    = pos_inc;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      lower_in  = lower_ff;
      colon_in  = colon_ff;
      flush     = 1'b0;
      emit_b    = 1'b0;

      if (eot) begin
         // Flush, mark the end, and return to the reset state.
         flush     = pending;
         emit_b    = 1'b1;
         mode_in   = MODE_IDLE;
         line_in   = '0;
         pos_in    = '0;
         pstart_in = '0;
         plen_in   = '0;
         lower_in  = 1'b0;
         colon_in  = 1'b0;
      end else if (mode_ff == MODE_COMMENT) begin
         if (text_byte == CHAR_NL) begin
            line_in = line_inc;
            mode_in = MODE_IDLE;
         end
      end else if ((mode_ff == MODE_WORD && is_word(text_byte)) ||
                   (mode_ff == MODE_OTHER && !is_space(text_byte) &&
                    !is_word(text_byte))) begin
         plen_in  = (plen_ff == LEN_MAX) ? plen_ff : plen_ff + 1'b1;
         lower_in = lower_ff || is_lower(text_byte);
         colon_in = (text_byte == CHAR_COLON);
      end else begin
         flush   = pending;
         mode_in = MODE_IDLE;
         if (is_space(text_byte)) begin
            if (text_byte == CHAR_NL) begin
               line_in = line_inc;
            end
         end else if (is_operator(text_byte)) begin
            emit_b             = 1'b1;
            b_rsp.kind         = operator_kind(text_byte);
            b_rsp.token_length = 8'd1;
            b_rsp.last_result  = 1'b0;
         end else if (text_byte == CHAR_HASH) begin
            mode_in = MODE_COMMENT;
         end else begin
            mode_in   = is_word(text_byte) ? MODE_WORD : MODE_OTHER;
            pstart_in = pos_ff;
            plen_in   = LENGTH_BITS'(1);
            lower_in  = is_lower(text_byte);
            colon_in  = (text_byte == CHAR_COLON);
         end
      end

      // Pack so the first descriptor always sits in slot a.
      results.count  = {1'b0, flush} + {1'b0, emit_b};
      results.slot_a = flush ? flush_rsp : b_rsp;
      results.slot_b = b_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= '0;
         pos_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
         lower_ff  <= 1'b0;
         colon_ff  <= 1'b0;
      end else if (step) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
         lower_ff  <= lower_in;
         colon_ff  <= colon_in;
      end
   end

endmodule

[sv/gtt_rsp_queue.sv]
// ----------------------------------------------------------------------------
// gtt_rsp_queue
// Small result queue: takes up to two descriptors a cycle, hands out one per pop.
// ----------------------------------------------------------------------------
module gtt_rsp_queue
   import gtt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_pair_type push_data,
   input  logic         pop,
   output logic         room,
   output logic         head_valid,
   output rsp_type      head,
   output logic [QPTR_BITS:0] fill
);

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic [1:0]             n_push;
   logic                   do_pop;

   assign n_push     = push ? push_data.count : 2'd0;
   assign head_valid = (count_ff != '0);
   assign do_pop     = pop && head_valid;
   assign head       = entry_ff[rd_ff];
   assign room       = (count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2));
   assign fill       = count_ff;

   always_comb begin
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      wr_in    = wr_ff + QPTR_BITS'(n_push);
      count_in = count_ff + (QPTR_BITS+1)'(n_push) - (QPTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   // Payload holds no reset.
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ff] <= push_data.slot_a;
      end
      if (n_push == 2'd2) begin
         entry_ff[wr_ff + 1'b1] <= push_data.slot_b;
      end
   end

endmodule

[sv/grammar_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// grammar_text_tokenizer
// Streaming lexer for grammar text: one byte in, token descriptors out.
// ----------------------------------------------------------------------------
// Feed the grammar text one byte per word on the req channel; raise req_tlast
// (or send a zero byte) to end the text. Each token comes out as one rsp word
// carrying its kind, line, start offset and length; the end marker closes the
// list with rsp_tlast high, after which line and offset restart at zero.
// Comments ('#' to newline) produce nothing. The block takes one byte per
// cycle while the result queue has room for a pair: a byte waits in the input
// register, then a scan step writes its zero, one or two descriptors into a
// four-entry result queue, which drains one descriptor per cycle while
// rsp_tready is high. Input throughput is set by the one-word-per-cycle rsp
// port: a byte that ends a word and is an operator yields two words, and the
// queue absorbs such bursts.
// ----------------------------------------------------------------------------
module grammar_text_tokenizer
   import gtt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [3:0] token_kind, [19:4] line_number,
                                    // [35:20] start_offset, [43:36] token_length,
                                    // [47:44] zero
   output logic        rsp_tlast    // last_result
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_eot_ff;
   logic         step;
   logic         room;
   rsp_pair_type results;
   rsp_type      head;
   logic [QPTR_BITS:0] fill;

   // Advance the scan when the queue can take a full pair.
   assign step        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the byte until the scan step takes it.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   gtt_lexer u_lexer (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .results     (results)
   );

   gtt_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (step),
      .push_data  (results),
      .pop        (rsp_tready),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head       (head),
      .fill       (fill)
   );

   assign rsp_tdata = {4'b0000, head.token_length, head.start_offset,
                       head.line_number, head.kind};
   assign rsp_tlast = head.last_result;

`ifndef SYNTHESIS
   // Queue never overfills.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // A scan step only happens with room for a pair.
   a_step_room: assert property (@(posedge clock) disable iff (reset)
      step |-> fill <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2))
      else $error("scan step without queue room");

   // Fill tracks pushes and pops.
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fill == $past(fill)
         + (QPTR_BITS+1)'($past(step) ? $past(results.count) : 2'd0)
         - (QPTR_BITS+1)'($past(rsp_tvalid && rsp_tready)))
      else $error("queue fill mismatch");

   // Only the end marker carries tlast.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (head.kind == KIND_END)))
      else $error("tlast and end kind disagree");
`endif

endmodule
